FILE: rtl/phdc_pkg.sv
package phdc_pkg;

  localparam int PosW = 33;
  localparam logic [PosW-1:0] PosMax = '1;
  localparam logic [5:0] HdrCrcStart = 6'd28;
  localparam logic [5:0] HdrDigestStart = 6'd32;
  localparam logic [5:0] HdrLastByte = 6'd63;
  localparam logic [PosW-1:0] HdrBytes = 33'd64;
  localparam logic [31:0] CrcPoly = 32'hEDB8_8320;

  localparam int CfgIndexW = 8;
  localparam logic [CfgIndexW-1:0] CfgMagicWord = 8'd0;
  localparam logic [CfgIndexW-1:0] CfgProtocolVersion = 8'd1;
  localparam logic [CfgIndexW-1:0] CfgPayloadLimit = 8'd2;
  localparam logic [CfgIndexW-1:0] CfgHighestTypeCode = 8'd3;

  typedef enum logic [1:0] {
    KindDigest  = 2'd0,
    KindPayload = 2'd1,
    KindStatus  = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    StOk       = 3'd0,
    StShort    = 3'd1,
    StMagic    = 3'd2,
    StVersion  = 3'd3,
    StType     = 3'd4,
    StTooLarge = 3'd5,
    StSize     = 3'd6,
    StCrc      = 3'd7
  } status_t;

  typedef struct packed {
    kind_t       out_kind;
    logic [7:0]  out_byte;
    status_t     status;
    logic [15:0] packet_type;
    logic [63:0] session_tag;
    logic [63:0] chunk_number;
    logic [31:0] payload_length;
  } result_t;

  typedef struct packed {
    logic [31:0] magic_word;
    logic [15:0] protocol_version;
    logic [31:0] payload_limit;
    logic [15:0] highest_type_code;
  } cfg_t;

  typedef struct packed {
    logic    data_valid;
    result_t data_res;
    logic    stat_valid;
    result_t stat_res;
  } push_t;

  function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

endpackage

FILE: rtl/phdc_if.sv
interface phdc_frame_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       frame_end;

  modport source (output valid, frame_byte, frame_end, input ready);
  modport sink (input valid, frame_byte, frame_end, output ready);
endinterface

interface phdc_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  out_kind;
  logic [7:0]  out_byte;
  logic [2:0]  status;
  logic [15:0] packet_type;
  logic [63:0] session_tag;
  logic [63:0] chunk_number;
  logic [31:0] payload_length;

  modport source (output valid, out_kind, out_byte, status, packet_type, session_tag,
                  chunk_number, payload_length, input ready);
  modport sink (input valid, out_kind, out_byte, status, packet_type, session_tag,
                chunk_number, payload_length, output ready);
endinterface

interface phdc_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [31:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: rtl/phdc_cfg_regs.sv
module phdc_cfg_regs (
  input  logic          clk,
  input  logic          rst,
  phdc_cfg_if.sink      cfg,
  output phdc_pkg::cfg_t regs
);
  import phdc_pkg::*;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.magic_word        <= 32'd0;
      regs.protocol_version  <= 16'd1;
      regs.payload_limit     <= 32'd1048576;
      regs.highest_type_code <= 16'd8;
    end else if (cfg.valid) begin
      case (cfg.index)
        CfgMagicWord:       regs.magic_word        <= cfg.data;
        CfgProtocolVersion: regs.protocol_version  <= cfg.data[15:0];
        CfgPayloadLimit:    regs.payload_limit     <= cfg.data;
        CfgHighestTypeCode: regs.highest_type_code <= cfg.data[15:0];
        default: ;
      endcase
    end
  end

endmodule

FILE: rtl/phdc_parse.sv
module phdc_parse (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic [7:0]      in_byte,
  input  logic            in_end,
  input  phdc_pkg::cfg_t  cfg,
  output phdc_pkg::push_t push
);
  import phdc_pkg::*;

  // input register
  logic       item_valid;
  logic [7:0] item_byte;
  logic       item_end;

  // frame state
  logic [PosW-1:0] byte_position;
  logic [31:0]     magic_seen;
  logic [15:0]     version_seen;
  logic [15:0]     type_seen;
  logic [63:0]     hash_seen;
  logic [63:0]     chunk_seen;
  logic [31:0]     length_seen;
  logic [31:0]     crc_seen;
  logic [31:0]     crc_running;
  status_t         first_error;

  logic [PosW-1:0] byte_position_next;
  logic [31:0]     magic_seen_next;
  logic [15:0]     version_seen_next;
  logic [15:0]     type_seen_next;
  logic [63:0]     hash_seen_next;
  logic [63:0]     chunk_seen_next;
  logic [31:0]     length_seen_next;
  logic [31:0]     crc_seen_next;
  logic [31:0]     crc_running_next;
  status_t         first_error_next;

  logic            in_hdr;
  logic [5:0]      lo;
  logic [7:0]      crc_in;
  logic [PosW-1:0] expect_count;
  status_t         stat;

  assign in_hdr = (byte_position[PosW-1:6] == '0);
  assign lo     = byte_position[5:0];
  assign crc_in = (lo >= HdrCrcStart && lo < HdrDigestStart) ? 8'd0 : item_byte;

  always_comb begin
    magic_seen_next   = magic_seen;
    version_seen_next = version_seen;
    type_seen_next    = type_seen;
    hash_seen_next    = hash_seen;
    chunk_seen_next   = chunk_seen;
    length_seen_next  = length_seen;
    crc_seen_next     = crc_seen;
    crc_running_next  = crc_running;
    first_error_next  = first_error;

    if (in_hdr) begin
      if (lo < 6'd4) begin
        magic_seen_next = {magic_seen[23:0], item_byte};
      end else if (lo < 6'd6) begin
        version_seen_next = {version_seen[7:0], item_byte};
      end else if (lo < 6'd8) begin
        type_seen_next = {type_seen[7:0], item_byte};
      end else if (lo < 6'd16) begin
        hash_seen_next = {hash_seen[55:0], item_byte};
      end else if (lo < 6'd24) begin
        chunk_seen_next = {chunk_seen[55:0], item_byte};
      end else if (lo < HdrCrcStart) begin
        length_seen_next = {length_seen[23:0], item_byte};
      end else if (lo < HdrDigestStart) begin
        crc_seen_next = {crc_seen[23:0], item_byte};
      end
      crc_running_next = crc32_byte(crc_running, crc_in);
    end

    if (in_hdr && lo == HdrLastByte) begin
      if (magic_seen != cfg.magic_word) begin
        first_error_next = StMagic;
      end else if (version_seen != cfg.protocol_version) begin
        first_error_next = StVersion;
      end else if (type_seen == 16'd0 || type_seen > cfg.highest_type_code) begin
        first_error_next = StType;
      end else if (length_seen > cfg.payload_limit) begin
        first_error_next = StTooLarge;
      end else if (~crc_running_next != crc_seen) begin
        first_error_next = StCrc;
      end else begin
        first_error_next = StOk;
      end
    end

    byte_position_next = (byte_position == PosMax) ? byte_position
                                                   : byte_position + 1'b1;
  end

  assign expect_count = HdrBytes + {1'b0, length_seen_next};

  always_comb begin
    if (byte_position_next < HdrBytes) begin
      stat = StShort;
    end else if (first_error_next == StMagic || first_error_next == StVersion ||
                 first_error_next == StType || first_error_next == StTooLarge) begin
      stat = first_error_next;
    end else if (byte_position_next != expect_count) begin
      stat = StSize;
    end else begin
      stat = first_error_next;
    end
  end

  always_comb begin
    push = '0;
    push.data_res.out_byte = item_byte;
    if (in_hdr) begin
      push.data_res.out_kind = KindDigest;
      push.data_valid = item_valid && (lo >= HdrDigestStart);
    end else begin
      push.data_res.out_kind = KindPayload;
      push.data_valid = item_valid && (first_error == StOk);
    end
    push.stat_valid                = item_valid && item_end;
    push.stat_res.out_kind         = KindStatus;
    push.stat_res.status           = stat;
    push.stat_res.packet_type      = type_seen_next;
    push.stat_res.session_tag      = hash_seen_next;
    push.stat_res.chunk_number     = chunk_seen_next;
    push.stat_res.payload_length   = length_seen_next;
  end

  always_ff @(posedge clk) begin
    item_byte <= in_byte;
    item_end  <= in_end;
    if (rst) begin
      item_valid    <= 1'b0;
      byte_position <= '0;
      magic_seen    <= '0;
      version_seen  <= '0;
      type_seen     <= '0;
      hash_seen     <= '0;
      chunk_seen    <= '0;
      length_seen   <= '0;
      crc_seen      <= '0;
      crc_running   <= '1;
      first_error   <= StOk;
    end else begin
      item_valid <= in_valid;
      if (item_valid) begin
        if (item_end) begin
          byte_position <= '0;
          magic_seen    <= '0;
          version_seen  <= '0;
          type_seen     <= '0;
          hash_seen     <= '0;
          chunk_seen    <= '0;
          length_seen   <= '0;
          crc_seen      <= '0;
          crc_running   <= '1;
          first_error   <= StOk;
        end else begin
          byte_position <= byte_position_next;
          magic_seen    <= magic_seen_next;
          version_seen  <= version_seen_next;
          type_seen     <= type_seen_next;
          hash_seen     <= hash_seen_next;
          chunk_seen    <= chunk_seen_next;
          length_seen   <= length_seen_next;
          crc_seen      <= crc_seen_next;
          crc_running   <= crc_running_next;
          first_error   <= first_error_next;
        end
      end
    end
  end

  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_end |=> byte_position == '0 && crc_running == '1)
    else $error("frame state not cleared after last byte");

  a_crc_frozen: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_end && !in_hdr |=> $stable(crc_running))
    else $error("crc moved past header");

  a_verdict_held: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_end && !in_hdr |=> $stable(first_error))
    else $error("header verdict changed in payload");

endmodule

FILE: rtl/phdc_result_fifo.sv
module phdc_result_fifo #(
  parameter int Depth = 8
) (
  input  logic            clk,
  input  logic            rst,
  input  phdc_pkg::push_t push,
  output logic            has_room,
  phdc_result_if.source   result
);
  import phdc_pkg::*;

  localparam int PtrW = $clog2(Depth);
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [CntW-1:0] RoomMax = CntW'(Depth - 4);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);

  result_t         mem [Depth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;
  logic [PtrW-1:0] wr_ptr_inc;
  logic [1:0]      n_push;
  logic            pop;
  result_t         head;
  result_t         first_res;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    return (p == PtrLast) ? '0 : p + 1'b1;
  endfunction

  assign wr_ptr_inc = ptr_inc(wr_ptr);
  assign n_push     = {1'b0, push.data_valid} + {1'b0, push.stat_valid};
  assign first_res  = push.data_valid ? push.data_res : push.stat_res;
  assign pop        = result.valid && result.ready;
  assign has_room   = (count <= RoomMax);
  assign head       = mem[rd_ptr];

  assign result.valid          = (count != '0);
  assign result.out_kind       = head.out_kind;
  assign result.out_byte       = head.out_byte;
  assign result.status         = head.status;
  assign result.packet_type    = head.packet_type;
  assign result.session_tag    = head.session_tag;
  assign result.chunk_number   = head.chunk_number;
  assign result.payload_length = head.payload_length;

  always_ff @(posedge clk) begin
    if (n_push != 2'd0) begin
      mem[wr_ptr] <= first_res;
    end
    if (n_push == 2'd2) begin
      mem[wr_ptr_inc] <= push.stat_res;
    end
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      case (n_push)
        2'd1:    wr_ptr <= wr_ptr_inc;
        2'd2:    wr_ptr <= ptr_inc(wr_ptr_inc);
        default: ;
      endcase
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      count <= count + CntW'(n_push) - CntW'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= CntW'(Depth))
    else $error("result queue overflow");

  a_pop_only: assert property (@(posedge clk) disable iff (rst)
    pop && n_push == 2'd0 |=> count == $past(count) - 1'b1)
    else $error("count wrong after pop");

  a_push_two: assert property (@(posedge clk) disable iff (rst)
    !pop && n_push == 2'd2 |=> count == $past(count) + 2'd2)
    else $error("count wrong after double push");

endmodule

FILE: rtl/packet_header_deframer_checker_core.sv
// Streaming deframer for frames with a 64-byte big-endian header protected by a
// CRC-32 (IEEE, header CRC bytes 28-31 counted as zero). Takes one frame byte per
// cycle while input ready is high: each transfer goes into an input register and
// is checked and decoded in the following cycle, so a byte can be taken on every
// clock. Digest bytes (header bytes 32-63) come out as they arrive, payload bytes
// only when the header passed, and the frame's last byte adds a status record
// after its own data transfer. Results wait in a small queue (FifoDepth entries);
// input ready drops only while that queue holds more than FifoDepth-4 results, so
// with the result side always ready the sustained rate is one byte per cycle; a
// result passes the input register and then the queue. Configuration writes are
// taken at any time and must only be issued while no frame is in flight.
module packet_header_deframer_checker_core #(
  parameter int FifoDepth = 8
) (
  input logic           clk,
  input logic           rst,
  phdc_frame_if.sink    frame,
  phdc_result_if.source result,
  phdc_cfg_if.sink      cfg
);
  import phdc_pkg::*;

  cfg_t  regs;
  push_t push;
  logic  has_room;

  assign frame.ready = has_room;

  phdc_cfg_regs u_cfg_regs (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  phdc_parse u_parse (
    .clk      (clk),
    .rst      (rst),
    .in_valid (frame.valid && has_room),
    .in_byte  (frame.frame_byte),
    .in_end   (frame.frame_end),
    .cfg      (regs),
    .push     (push)
  );

  phdc_result_fifo #(
    .Depth (FifoDepth)
  ) u_result_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .has_room (has_room),
    .result   (result)
  );

endmodule
